// File: rtl/slt_pkg.sv
// slt_pkg: shared types and constants for the script line tokenizer.
// No dependencies; imported by every module under rtl/.
package slt_pkg;

   // Lexer modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_CONT    = 3'd2;
   localparam logic [2:0] MODE_QUOTE   = 3'd3;
   localparam logic [2:0] MODE_TEXT    = 3'd4;

   // Result event codes
   localparam logic [2:0] EV_START   = 3'd0;
   localparam logic [2:0] EV_BYTE    = 3'd1;
   localparam logic [2:0] EV_END     = 3'd2;
   localparam logic [2:0] EV_NEWLINE = 3'd3;
   localparam logic [2:0] EV_EOI     = 3'd4;

   // Input kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOD  = 1'b1;

   // Characters of interest
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // One queue entry: the one or two result beats caused by one input beat.
   // Only token byte events carry data, and at most one per entry.
   typedef struct packed {
      logic       two;
      logic [2:0] ev0;
      logic [2:0] ev1;
      logic [7:0] data;
   } slt_entry_type;

endpackage

// File: rtl/slt_front.sv
// slt_front: accepts input beats, tracks the lexer mode and classifies each
// byte into zero, one or two result events. Depends on slt_pkg.
module slt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   input  logic [7:0]             req_byte_value,
   input  logic                   queue_full,
   output logic                   req_stall,
   output logic                   push,
   output slt_pkg::slt_entry_type push_entry
);
   import slt_pkg::*;

   logic [2:0]    mode_ff;
   logic [2:0]    mode_in;
   logic          accept;
   logic          has0;
   slt_entry_type ent;
   // idle-mode handling of the current byte
   logic          idle_has;
   logic          idle_two;
   logic [2:0]    idle_ev0;
   logic [2:0]    idle_ev1;
   logic [2:0]    idle_mode;
   logic [7:0]    c;

   assign c         = req_byte_value;
   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   always_comb begin
      idle_has  = 1'b0;
      idle_two  = 1'b0;
      idle_ev0  = EV_START;
      idle_ev1  = EV_BYTE;
      idle_mode = MODE_IDLE;
      if (c inside {CH_TAB, CH_CR, CH_SPACE, CH_NUL}) begin
         idle_mode = MODE_IDLE;
      end else if (c == CH_HASH) begin
         idle_mode = MODE_COMMENT;
      end else if (c == CH_NEWLINE) begin
         idle_has = 1'b1;
         idle_ev0 = EV_NEWLINE;
      end else if (c == CH_BACKSLASH) begin
         idle_mode = MODE_CONT;
      end else if (c == CH_DQUOTE) begin
         idle_has  = 1'b1;
         idle_ev0  = EV_START;
         idle_mode = MODE_QUOTE;
      end else begin
         idle_has  = 1'b1;
         idle_two  = 1'b1;
         idle_ev0  = EV_START;
         idle_ev1  = EV_BYTE;
         idle_mode = MODE_TEXT;
      end
   end

   always_comb begin
      has0     = 1'b0;
      ent.two  = 1'b0;
      ent.ev0  = EV_EOI;
      ent.ev1  = EV_EOI;
      ent.data = c;
      mode_in  = mode_ff;
      if (req_kind == KIND_EOD) begin
         has0    = 1'b1;
         mode_in = MODE_IDLE;
         if (mode_ff == MODE_TEXT || mode_ff == MODE_QUOTE) begin
            ent.two = 1'b1;
            ent.ev0 = EV_END;
            ent.ev1 = EV_EOI;
         end else begin
            ent.ev0 = EV_EOI;
         end
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  has0    = 1'b1;
                  ent.ev0 = EV_NEWLINE;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_CONT: begin
               if (c == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_QUOTE: begin
               has0 = 1'b1;
               if (c == CH_DQUOTE) begin
                  ent.ev0 = EV_END;
                  mode_in = MODE_IDLE;
               end else begin
                  ent.ev0 = EV_BYTE;
               end
            end
            MODE_TEXT: begin
               has0 = 1'b1;
               if (c inside {CH_TAB, CH_CR, CH_NUL, CH_SPACE, CH_NEWLINE, CH_HASH}) begin
                  // terminator: end the token, then treat the byte as in idle
                  ent.ev0 = EV_END;
                  ent.two = idle_has;
                  ent.ev1 = idle_ev0;
                  mode_in = idle_mode;
               end else begin
                  ent.ev0 = EV_BYTE;
               end
            end
            default: begin
               has0    = idle_has;
               ent.two = idle_two;
               ent.ev0 = idle_ev0;
               ent.ev1 = idle_ev1;
               mode_in = idle_mode;
            end
         endcase
      end
   end

   assign push       = accept & has0;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// File: rtl/slt_queue.sv
// slt_queue: small FIFO of classified entries between front and back.
// Depends on slt_pkg for the entry type.
module slt_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  slt_pkg::slt_entry_type push_entry,
   input  logic                   pop,
   output slt_pkg::slt_entry_type head_entry,
   output logic                   empty,
   output logic                   full
);
   import slt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   slt_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_FULL);
   assign do_push    = push & ~full;
   assign do_pop     = pop & ~empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/slt_back.sv
// slt_back: drains queue entries into the registered result channel, one or
// two beats per entry. Depends on slt_pkg.
module slt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  slt_pkg::slt_entry_type head_entry,
   input  logic                   empty,
   output logic                   pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_event_res,
   output logic [7:0]             rsp_token_byte,
   output logic                   rsp_last
);
   import slt_pkg::*;

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;   // first beat of a two-beat head already sent
   logic [2:0] event_ff, event_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      event_in = event_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = ~empty;
         if (!empty) begin
            if (head_entry.two && !phase_ff) begin
               event_in = head_entry.ev0;
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               event_in = phase_ff ? head_entry.ev1 : head_entry.ev0;
               last_in  = 1'b1;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
            byte_in = (event_in == EV_BYTE) ? head_entry.data : 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_event_res  = event_ff;
   assign rsp_token_byte = byte_ff;
   assign rsp_last       = last_ff;

endmodule

// File: rtl/script_line_tokenizer.sv
// script_line_tokenizer: streaming tokenizer, one script byte per beat.
// Accepted items are queued; the output register loads result beats from the head.
// Throughput: one input beat per cycle while the queue has room; output stalls and
//   two-beat items, which load the output register twice, can fill it (req_stall).
// Reset (synchronous, active high): lexer idle, queue empty, no result valid.
// Depends on slt_pkg, slt_front, slt_queue, slt_back.
module script_line_tokenizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_byte_value,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);
   import slt_pkg::*;

   // front -> queue
   logic          push;
   slt_entry_type push_entry;
   // queue -> back
   slt_entry_type head_entry;
   logic          empty;
   logic          full;
   logic          pop;

   // Front: mode tracking and classification. A beat whose byte gives no
   // result (separator, comment text, continuation) updates the mode only.
   slt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .queue_full     (full),
      .req_stall      (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Decouples the front from output back-pressure.
   slt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (empty),
      .full       (full)
   );

   // Back: splits each entry into its result beats, last flag on the final one.
   slt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .empty          (empty),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

endmodule

// File: bench/token_stream_checker.sv
`timescale 1ns / 1ps
// token_stream_checker: watches both channels of script_line_tokenizer, predicts the
// token beats and compares them in order. Depends on slt_pkg.
module token_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_byte_value,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_event_res,
   input  logic [7:0] rsp_token_byte,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         pending_tokens
);
   import slt_pkg::*;

   typedef struct packed {
      logic [2:0] ev;
      logic [7:0] tok;
      logic       last;
   } token_beat_type;

   token_beat_type expected_tokens[$];
   token_beat_type item_tokens[$];
   logic [2:0]     lex_mode;

   function automatic bit is_gap(logic [7:0] ch);
      return ch == CH_TAB || ch == CH_CR || ch == CH_SPACE || ch == CH_NUL;
   endfunction

   function void emit(logic [2:0] ev, logic [7:0] ch);
      item_tokens.push_back('{ev, ch, 1'b0});
   endfunction

   // handling of a byte seen between tokens
   function void enter_from_idle(logic [7:0] ch);
      if (is_gap(ch)) begin
         lex_mode = MODE_IDLE;
      end else if (ch == CH_HASH) begin
         lex_mode = MODE_COMMENT;
      end else if (ch == CH_NEWLINE) begin
         emit(EV_NEWLINE, 8'h00);
         lex_mode = MODE_IDLE;
      end else if (ch == CH_BACKSLASH) begin
         lex_mode = MODE_CONT;
      end else if (ch == CH_DQUOTE) begin
         emit(EV_START, 8'h00);
         lex_mode = MODE_QUOTE;
      end else begin
         emit(EV_START, 8'h00);
         emit(EV_BYTE, ch);
         lex_mode = MODE_TEXT;
      end
   endfunction

   function void tokenize_beat(logic kind, logic [7:0] ch);
      item_tokens.delete();
      if (kind == KIND_EOD) begin
         if (lex_mode == MODE_TEXT || lex_mode == MODE_QUOTE)
            emit(EV_END, 8'h00);
         emit(EV_EOI, 8'h00);
         lex_mode = MODE_IDLE;
      end else begin
         case (lex_mode)
            MODE_COMMENT: begin
               if (ch == CH_NEWLINE) begin
                  emit(EV_NEWLINE, 8'h00);
                  lex_mode = MODE_IDLE;
               end
            end
            MODE_CONT: begin
               if (ch == CH_NEWLINE)
                  lex_mode = MODE_IDLE;
            end
            MODE_QUOTE: begin
               if (ch == CH_DQUOTE) begin
                  emit(EV_END, 8'h00);
                  lex_mode = MODE_IDLE;
               end else begin
                  emit(EV_BYTE, ch);
               end
            end
            MODE_TEXT: begin
               if (is_gap(ch) || ch == CH_NEWLINE || ch == CH_HASH) begin
                  emit(EV_END, 8'h00);
                  enter_from_idle(ch);
               end else begin
                  emit(EV_BYTE, ch);
               end
            end
            default: enter_from_idle(ch);
         endcase
      end
      if (item_tokens.size() > 0)
         item_tokens[item_tokens.size() - 1].last = 1'b1;
      foreach (item_tokens[i])
         expected_tokens.push_back(item_tokens[i]);
   endfunction

   always @(posedge clock) begin
      token_beat_type want;
      if (reset) begin
         lex_mode = MODE_IDLE;
         expected_tokens.delete();
      end else begin
         if (req_valid && !req_stall)
            tokenize_beat(req_kind, req_byte_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected beat: ev=%0d byte=%02h last=%0b", $realtime,
                           rsp_event_res, rsp_token_byte, rsp_last);
            end else begin
               want = expected_tokens.pop_front();
               if (want.ev !== rsp_event_res || want.tok !== rsp_token_byte ||
                   want.last !== rsp_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch: expected ev=%0d byte=%02h last=%0b, ",
                               "got ev=%0d byte=%02h last=%0b"},
                              $realtime, want.ev, want.tok, want.last,
                              rsp_event_res, rsp_token_byte, rsp_last);
               end
            end
         end
      end
      pending_tokens = expected_tokens.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for script_line_tokenizer; prediction lives in
// token_stream_checker. Depends on slt_pkg and the RTL under rtl/.
module tb;
   import slt_pkg::*;

   localparam int BEAT_TARGET  = 1550;   // input beats to send
   localparam int CALM_TAIL    = 250;    // last stretch runs with no idling on either side
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off, fills the block up
   localparam int DRAIN_CYCLES = 20;     // drain margin for the output register, with two-beat items on top
   localparam int CYCLE_LIMIT  = 400000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_kind;
   logic [7:0] req_byte_value;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_event_res;
   logic [7:0] rsp_token_byte;
   logic       rsp_last;

   int mismatch_count;
   int pending_tokens;
   int beats_sent;
   int cycle_count;
   bit idling_on;
   bit hold_request;

   script_line_tokenizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

   token_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_res  (rsp_event_res),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_tokens (pending_tokens)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   // Stall only ever changes at a falling edge, and at most once per edge.
   initial begin
      int hold_count;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Drive one beat from a falling edge and return at the falling edge after
   // it was taken. A random gap may come first; valid is touched once per edge.
   task automatic send_beat(input logic kind, input logic [7:0] ch);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= ch;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // Bytes that can start a text token but cannot end one
   function automatic logic [7:0] plain_char();
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(0, 255));
      while (ch == CH_NUL || ch == CH_TAB || ch == CH_NEWLINE || ch == CH_CR ||
             ch == CH_SPACE || ch == CH_DQUOTE || ch == CH_HASH || ch == CH_BACKSLASH);
      return ch;
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] banned);
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(0, 255));
      while (ch == banned);
      return ch;
   endfunction

   // Comment or continuation body: dropped by the block, then closed by a
   // newline or, now and then, by end of data.
   task automatic send_dropped_run(input int len);
      for (int i = 0; i < len; i++) begin
         send_beat(KIND_DATA, any_but(CH_NEWLINE));
      end
      if ($urandom_range(0, 7) == 0)
         send_beat(KIND_EOD, 8'($urandom_range(0, 255)));
      else
         send_beat(KIND_DATA, CH_NEWLINE);
   endtask

   initial begin
      logic [7:0] text_ends[6];
      int         len;
      int         pick;
      bit         hold_done;

      text_ends = '{CH_TAB, CH_CR, CH_SPACE, CH_NUL, CH_NEWLINE, CH_HASH};
      hold_done      = 1'b0;
      hold_request   = 1'b0;
      idling_on      = 1'b1;
      beats_sent     = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_DATA;
      req_byte_value = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: end of data while idle (byte ignored), text holding quote,
      // backslash and 8'hFF ended by NUL, quoted token holding newline, NUL
      // and '#', empty quoted pair, '#' ending text, NUL dropped in a comment,
      // continuation swallowing a quote, stray NUL, newline ending text
      // (end then newline token), end of data inside quotes.
      send_beat(KIND_EOD, 8'hFF);
      send_beat(KIND_DATA, "a");          send_beat(KIND_DATA, CH_DQUOTE);
      send_beat(KIND_DATA, CH_BACKSLASH); send_beat(KIND_DATA, 8'hFF);
      send_beat(KIND_DATA, CH_NUL);
      send_beat(KIND_DATA, CH_DQUOTE);    send_beat(KIND_DATA, CH_NEWLINE);
      send_beat(KIND_DATA, CH_NUL);       send_beat(KIND_DATA, CH_HASH);
      send_beat(KIND_DATA, CH_DQUOTE);
      send_beat(KIND_DATA, CH_DQUOTE);    send_beat(KIND_DATA, CH_DQUOTE);
      send_beat(KIND_DATA, "x");          send_beat(KIND_DATA, CH_HASH);
      send_beat(KIND_DATA, CH_NUL);       send_beat(KIND_DATA, CH_NEWLINE);
      send_beat(KIND_DATA, CH_BACKSLASH); send_beat(KIND_DATA, CH_DQUOTE);
      send_beat(KIND_DATA, CH_NEWLINE);
      send_beat(KIND_DATA, CH_NUL);
      send_beat(KIND_DATA, "z");          send_beat(KIND_DATA, CH_NEWLINE);
      send_beat(KIND_DATA, CH_DQUOTE);    send_beat(KIND_EOD, 8'h00);

      // Random: mostly well-formed fragments of a script, some noise.
      while (beats_sent < BEAT_TARGET) begin
         if (!hold_done && beats_sent > HOLD_AT) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (beats_sent > BEAT_TARGET - CALM_TAIL)
            idling_on = 1'b0;
         else if ($urandom_range(0, 15) == 0)
            idling_on = ~idling_on;   // stretches with and without idling

         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // text token; quote and backslash may sit inside it
               len = $urandom_range(1, 8);
               send_beat(KIND_DATA, plain_char());
               for (int i = 1; i < len; i++) begin
                  if ($urandom_range(0, 7) == 0)
                     send_beat(KIND_DATA, $urandom_range(0, 1) ? CH_DQUOTE : CH_BACKSLASH);
                  else
                     send_beat(KIND_DATA, plain_char());
               end
               pick = $urandom_range(0, 6);
               if (pick == 6) begin
                  send_beat(KIND_EOD, 8'($urandom_range(0, 255)));
               end else begin
                  send_beat(KIND_DATA, text_ends[pick]);
                  if (text_ends[pick] == CH_HASH)
                     send_dropped_run($urandom_range(0, 4));
               end
            end
            4, 5: begin
               // quoted token, maybe empty, maybe cut off by end of data
               send_beat(KIND_DATA, CH_DQUOTE);
               len = $urandom_range(0, 8);
               for (int i = 0; i < len; i++)
                  send_beat(KIND_DATA, any_but(CH_DQUOTE));
               if ($urandom_range(0, 7) == 0)
                  send_beat(KIND_EOD, 8'($urandom_range(0, 255)));
               else
                  send_beat(KIND_DATA, CH_DQUOTE);
            end
            6: begin
               send_beat(KIND_DATA, CH_HASH);
               send_dropped_run($urandom_range(0, 6));
            end
            7: begin
               send_beat(KIND_DATA, CH_BACKSLASH);
               send_dropped_run($urandom_range(0, 6));
            end
            8: begin
               pick = $urandom_range(0, 5);
               if (pick < 4) begin
                  send_beat(KIND_DATA, text_ends[pick]);
               end else if (pick == 4) begin
                  send_beat(KIND_DATA, CH_NEWLINE);
               end else begin
                  send_beat(KIND_EOD, 8'($urandom_range(0, 255)));
               end
            end
            default: begin
               // noise: any byte, any kind, breaks whatever came before
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++)
                  send_beat(($urandom_range(0, 7) == 0) ? KIND_EOD : KIND_DATA,
                            8'($urandom_range(0, 255)));
            end
         endcase
      end

      req_valid <= 1'b0;
      wait (pending_tokens == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_tokens == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
